### src/nit_network_name_extractor_assert.svh
// assertion helpers shared by the block's modules
`ifndef NIT_NETWORK_NAME_EXTRACTOR_ASSERT_SVH
`define NIT_NETWORK_NAME_EXTRACTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NIT_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define NIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/nit_pkg.sv
package nit_pkg;

  localparam int MAX_SECTION_BYTES_DEF = 1024;
  localparam int MAX_NAME_BYTES_DEF    = 30;

  localparam logic [7:0] NAME_TAG    = 8'h40;
  localparam int         WALK_START  = 10;
  localparam int         MIN_SECTION = 24;
  localparam int         LOOP_LEN_W  = 12;
  localparam int         CMD_DEPTH   = 4;

  // command from parser to readout side
  typedef struct packed {
    logic       wr;
    logic [7:0] data;
    logic       emit;
    logic       found;
  } cmd_t;

endpackage

### src/nit_front.sv
module nit_front #(
  parameter int MAX_SECTION_BYTES = nit_pkg::MAX_SECTION_BYTES_DEF,
  parameter int MAX_NAME_BYTES    = nit_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  output logic          cmd_push,
  output nit_pkg::cmd_t cmd,
  input  logic          cmd_full
);

  `include "nit_network_name_extractor_assert.svh"

  localparam int POS_W  = $clog2(MAX_SECTION_BYTES + 1);
  localparam int OFF_RAW = $clog2(MAX_SECTION_BYTES + 257);
  localparam int OFF_W  = (OFF_RAW > nit_pkg::LOOP_LEN_W) ? OFF_RAW : nit_pkg::LOOP_LEN_W;
  localparam int CNT_W  = $clog2(MAX_NAME_BYTES + 1);

  typedef enum logic [2:0] {
    PH_HEADER, PH_WALK, PH_NAME_LEN, PH_SKIP_LEN, PH_NAME, PH_DONE
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [POS_W-1:0]                 pos_r, pos_nxt;
  logic [nit_pkg::LOOP_LEN_W-1:0]   loop_len_r, loop_len_nxt;
  logic [OFF_W-1:0]                 off_r, off_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [CNT_W-1:0]                 tgt_r, tgt_nxt;
  logic                             seen_r, seen_nxt;
  logic                             accept;
  logic                             parse;
  logic                             wr;
  logic                             found;

  assign in_tready = !cmd_full;
  assign accept    = in_tvalid && in_tready;
  assign parse     = pos_r < POS_W'(MAX_SECTION_BYTES);

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    loop_len_nxt = loop_len_r;
    off_nxt      = off_r;
    cnt_nxt      = cnt_r;
    tgt_nxt      = tgt_r;
    seen_nxt     = seen_r;
    wr           = 1'b0;
    found        = 1'b0;
    if (parse) begin
      pos_nxt = pos_r + POS_W'(1);
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_W'(8)) begin
            loop_len_nxt = {in_tdata[3:0], 8'h00};
          end else if (pos_r == POS_W'(9)) begin
            loop_len_nxt = {loop_len_r[11:8], in_tdata};
            phase_nxt    = PH_WALK;
          end
        end
        PH_WALK: begin
          if (OFF_W'(pos_r) == off_r) begin
            if ((off_r - OFF_W'(nit_pkg::WALK_START)) >= OFF_W'(loop_len_r)) begin
              phase_nxt = PH_DONE;
            end else if (in_tdata == nit_pkg::NAME_TAG) begin
              seen_nxt  = 1'b1;
              phase_nxt = PH_NAME_LEN;
            end else begin
              phase_nxt = PH_SKIP_LEN;
            end
          end
        end
        PH_SKIP_LEN: begin
          off_nxt   = off_r + OFF_W'(in_tdata) + OFF_W'(2);
          phase_nxt = PH_WALK;
        end
        PH_NAME_LEN: begin
          if ({1'b0, in_tdata} > 9'(MAX_NAME_BYTES)) begin
            tgt_nxt = CNT_W'(MAX_NAME_BYTES);
          end else begin
            tgt_nxt = CNT_W'(in_tdata);
          end
          cnt_nxt   = '0;
          phase_nxt = (in_tdata == 8'h00) ? PH_DONE : PH_NAME;
        end
        PH_NAME: begin
          wr      = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_nxt >= tgt_r) begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    if (in_tlast) begin
      found        = (pos_nxt > POS_W'(nit_pkg::MIN_SECTION)) && seen_nxt && (cnt_nxt != '0);
      phase_nxt    = PH_HEADER;
      pos_nxt      = '0;
      loop_len_nxt = '0;
      off_nxt      = OFF_W'(nit_pkg::WALK_START);
      cnt_nxt      = '0;
      tgt_nxt      = '0;
      seen_nxt     = 1'b0;
    end
  end

  assign cmd_push   = accept && (wr || in_tlast);
  assign cmd.wr     = wr;
  assign cmd.data   = in_tdata;
  assign cmd.emit   = in_tlast;
  assign cmd.found  = found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      loop_len_r <= '0;
      off_r      <= OFF_W'(nit_pkg::WALK_START);
      cnt_r      <= '0;
      tgt_r      <= '0;
      seen_r     <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      loop_len_r <= loop_len_nxt;
      off_r      <= off_nxt;
      cnt_r      <= cnt_nxt;
      tgt_r      <= tgt_nxt;
      seen_r     <= seen_nxt;
    end
  end

  `NIT_ASSERT_HOLDS(a_name_room, phase_r == PH_NAME, cnt_r < tgt_r, "name phase with full count")
  `NIT_ASSERT_HOLDS(a_cap, 1'b1, cnt_r <= CNT_W'(MAX_NAME_BYTES), "name count past capacity")

endmodule

### src/nit_cmd_fifo.sv
module nit_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nit_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output nit_pkg::cmd_t dout,
  output logic          empty
);

  `include "nit_network_name_extractor_assert.svh"

  localparam int PTR_W = $clog2(nit_pkg::CMD_DEPTH);
  localparam int CNT_W = $clog2(nit_pkg::CMD_DEPTH + 1);

  nit_pkg::cmd_t    mem_r [nit_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = cnt_r == CNT_W'(nit_pkg::CMD_DEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `NIT_ASSERT_HOLDS(a_no_underrun, pop, !empty, "pop from empty command queue")
  `NIT_ASSERT_HOLDS(a_no_overrun, push, !full, "push into full command queue")

endmodule

### src/nit_back.sv
module nit_back #(
  parameter int MAX_NAME_BYTES = nit_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  nit_pkg::cmd_t cmd,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast,
  output logic          out_tuser
);

  `include "nit_network_name_extractor_assert.svh"

  localparam int CNT_W = $clog2(MAX_NAME_BYTES + 1);
  localparam int IDX_W = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

  typedef enum logic {
    ST_IDLE, ST_EMIT
  } state_t;

  state_t           state_r;
  logic [7:0]       name_mem [MAX_NAME_BYTES];
  logic [CNT_W-1:0] wr_ptr_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             job_found_r;
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;
  logic             out_found_r;
  logic             load;
  logic             at_end;

  assign cmd_pop    = (state_r == ST_IDLE) && !cmd_empty;
  assign load       = !out_valid_r || out_tready;
  assign at_end     = (CNT_W'(rd_idx_r) + CNT_W'(1)) == wr_ptr_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_found_r;

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.wr) begin
      name_mem[wr_ptr_r[IDX_W-1:0]] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_EMIT) && load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd.wr) begin
              wr_ptr_r <= wr_ptr_r + CNT_W'(1);
            end
            if (cmd.emit) begin
              job_found_r <= cmd.found;
              rd_idx_r    <= '0;
              state_r     <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (load) begin
            if (!job_found_r) begin
              out_data_r  <= 8'h00;
              out_found_r <= 1'b0;
              out_last_r  <= 1'b1;
              wr_ptr_r    <= '0;
              state_r     <= ST_IDLE;
            end else begin
              out_data_r  <= name_mem[rd_idx_r];
              out_found_r <= 1'b1;
              out_last_r  <= at_end;
              rd_idx_r    <= rd_idx_r + IDX_W'(1);
              if (at_end) begin
                wr_ptr_r <= '0;
                state_r  <= ST_IDLE;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `NIT_ASSERT_HOLDS(a_run_nonempty, (state_r == ST_EMIT) && job_found_r, wr_ptr_r != '0,
                    "name run with no stored bytes")
  `NIT_ASSERT_HOLDS(a_empty_is_last, out_valid_r && !out_found_r, out_last_r,
                    "empty result not marked last")
  `NIT_ASSERT_NEXT(a_stall_holds, out_valid_r && !out_tready,
                   out_valid_r && $stable(out_data_r) && $stable(out_last_r),
                   "stalled result changed")

endmodule

### src/nit_network_name_extractor.sv
// Network name extractor: takes one network information table section a beat at a time on
// in_* (tlast on the final byte), walks the descriptor loop and keeps the payload of the
// network name descriptor (tag 0x40), clamped to MAX_NAME_BYTES. After the final byte it
// sends the name on out_* one byte per beat with tuser=1 and tlast on the last byte, or a
// single beat of 0 with tuser=0 when there is no name or the section is 24 bytes or shorter.
// The parser takes one byte per cycle; it hands name bytes and the end-of-section job to the
// readout side through a 4-entry command queue. The first result beat is registered after the
// end-of-section job leaves the queue; a name of N bytes then leaves one beat per cycle while
// out_tready is high. The next section streams in during readout; it stalls only when the
// queue fills, which takes four name bytes or section ends while the readout is busy.
module nit_network_name_extractor #(
  parameter int MAX_SECTION_BYTES = nit_pkg::MAX_SECTION_BYTES_DEF,
  parameter int MAX_NAME_BYTES    = nit_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // name_byte
  output logic       out_tlast,
  output logic       out_tuser   // found
);

  nit_pkg::cmd_t push_cmd;
  nit_pkg::cmd_t pop_cmd;
  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_pop;
  logic          cmd_empty;

  nit_front #(
    .MAX_SECTION_BYTES (MAX_SECTION_BYTES),
    .MAX_NAME_BYTES    (MAX_NAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd),
    .cmd_full  (cmd_full)
  );

  nit_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (push_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (pop_cmd),
    .empty (cmd_empty)
  );

  nit_back #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .cmd        (pop_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BUILD    = 64;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_WALK,
    PH_NAME_LEN,
    PH_SKIP_LEN,
    PH_NAME,
    PH_DONE
  } walk_phase_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       found;
    logic       run_end;
  } name_beat_t;

  // one section as the driver builds it
  typedef struct packed {
    logic [10:0] sec_len;
    logic [11:0] loop_len;
    logic [3:0]  hi_nib;
    logic [2:0]  n_skip;
    logic [7:0]  skip_len;
    logic        has_name;
    logic [7:0]  name_len;
    logic        empty_known;
    logic        noise;
  } section_t;

  localparam name_beat_t EMPTY_BEAT = '{name_byte: 8'h00, found: 1'b0, run_end: 1'b1};

  // sec_len, loop_len, hi_nib, n_skip, skip_len, has_name, name_len, empty_known, noise
  localparam section_t DIRECTED [0:4] = '{
    '{11'd1,  12'h000, 4'h0, 3'd0, 8'd0, 1'b0, 8'd0,  1'b1, 1'b0}, // one-byte section
    '{11'd24, 12'h0FF, 4'h0, 3'd0, 8'd0, 1'b1, 8'd8,  1'b1, 1'b0}, // short section
    '{11'd25, 12'h001, 4'hF, 3'd0, 8'd0, 1'b1, 8'd20, 1'b0, 1'b0}, // cut by end, past loop
    '{11'd25, 12'h100, 4'h0, 3'd2, 8'd5, 1'b1, 8'd5,  1'b1, 1'b0}, // ends on tag byte
    '{11'd42, 12'hFFF, 4'hF, 3'd0, 8'd0, 1'b1, 8'hFF, 1'b0, 1'b0}  // name clamped
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // data_byte
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // name_byte
  logic       out_tlast;
  logic       out_tuser;          // found

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  name_beat_t name_q[$];
  logic       empty_known_q[$];

  // predictor state
  logic [10:0]  sec_pos = '0;
  logic [11:0]  loop_len = '0;
  logic [11:0]  next_off = 12'(nit_pkg::WALK_START);
  walk_phase_t  walk_phase = PH_HEADER;
  logic [7:0]   name_store [0:nit_pkg::MAX_NAME_BYTES_DEF-1];
  logic [4:0]   name_cnt = '0;
  logic [4:0]   name_target = '0;
  logic         name_seen = 1'b0;

  nit_network_name_extractor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void track_section_byte(logic [7:0] b, logic last, logic empty_known);
    name_beat_t beat;
    if (sec_pos < 11'(nit_pkg::MAX_SECTION_BYTES_DEF)) begin
      case (walk_phase)
        PH_HEADER: begin
          if (sec_pos == 11'd8) begin
            loop_len = {b[3:0], 8'h00};
          end else if (sec_pos == 11'd9) begin
            loop_len = loop_len | 12'(b);
            walk_phase = PH_WALK;
          end
        end
        PH_WALK: begin
          if (12'(sec_pos) == next_off) begin
            if (next_off - 12'(nit_pkg::WALK_START) >= loop_len) begin
              walk_phase = PH_DONE;
            end else if (b == nit_pkg::NAME_TAG) begin
              name_seen = 1'b1;
              walk_phase = PH_NAME_LEN;
            end else begin
              walk_phase = PH_SKIP_LEN;
            end
          end
        end
        PH_SKIP_LEN: begin
          next_off = next_off + 12'(b) + 12'd2;
          walk_phase = PH_WALK;
        end
        PH_NAME_LEN: begin
          name_target = (b > 8'(nit_pkg::MAX_NAME_BYTES_DEF)) ?
                        5'(nit_pkg::MAX_NAME_BYTES_DEF) : b[4:0];
          name_cnt = '0;
          walk_phase = (name_target == '0) ? PH_DONE : PH_NAME;
        end
        PH_NAME: begin
          if (name_cnt < name_target) begin
            name_store[name_cnt] = b;
            name_cnt = name_cnt + 5'd1;
          end
          if (name_cnt >= name_target) begin
            walk_phase = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      sec_pos = sec_pos + 11'd1;
    end
    if (last) begin
      if (!empty_known && sec_pos > 11'(nit_pkg::MIN_SECTION) && name_seen && name_cnt != '0) begin
        for (int k = 0; k < int'(name_cnt); k++) begin
          beat.name_byte = name_store[k];
          beat.found     = 1'b1;
          beat.run_end   = (k + 1 == int'(name_cnt));
          name_q.push_back(beat);
        end
      end else begin
        name_q.push_back(EMPTY_BEAT);
      end
      sec_pos     = '0;
      loop_len    = '0;
      next_off    = 12'(nit_pkg::WALK_START);
      walk_phase  = PH_HEADER;
      name_cnt    = '0;
      name_target = '0;
      name_seen   = 1'b0;
    end
  endfunction

  // check outgoing beats first, then predict from the incoming one
  always @(posedge clk) begin
    name_beat_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (name_q.size() == 0) begin
          $error("unexpected result beat: name_byte %0h found %0b run_end %0b",
                 out_tdata, out_tuser, out_tlast);
          fail_count++;
        end else begin
          want = name_q.pop_front();
          if (out_tdata !== want.name_byte) begin
            $error("name_byte: expected %0h, got %0h", want.name_byte, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_tuser);
            fail_count++;
          end
          if (out_tlast !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        track_section_byte(in_tdata, in_tlast, in_tlast ? empty_known_q.pop_front() : 1'b0);
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("nit_network_name_extractor test failed");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_section(input section_t s);
    logic [7:0] sec [0:MAX_BUILD-1];
    int         off;
    logic [7:0] tag;
    for (int i = 0; i < MAX_BUILD; i++) begin
      sec[i] = 8'($urandom_range(0, 255));
    end
    if (!s.noise) begin
      sec[8] = {s.hi_nib, s.loop_len[11:8]};
      sec[9] = s.loop_len[7:0];
      off = nit_pkg::WALK_START;
      for (int k = 0; k < int'(s.n_skip); k++) begin
        tag = 8'($urandom_range(0, 255));
        if (tag == nit_pkg::NAME_TAG) begin
          tag = tag + 8'd1;
        end
        sec[off]     = tag;
        sec[off + 1] = s.skip_len;
        off = off + int'(s.skip_len) + 2;
      end
      if (s.has_name && off + 1 < MAX_BUILD) begin
        sec[off]     = nit_pkg::NAME_TAG;
        sec[off + 1] = s.name_len;
      end
    end
    empty_known_q.push_back(s.empty_known);
    for (int i = 0; i < int'(s.sec_len); i++) begin
      send_beat(sec[i], i == int'(s.sec_len) - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (name_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_random_phase(input int gap_pct, input int stall_pct);
    section_t s;
    int       phase_bytes;
    int       name_off;
    int       pick;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    phase_bytes    = 0;
    while (phase_bytes < 16) begin
      s = '0;
      if ($urandom_range(0, 99) < 20) begin
        s.noise   = 1'b1;
        s.sec_len = 11'($urandom_range(1, 30));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          s.sec_len = 11'($urandom_range(1, 24));
        end else begin
          s.sec_len = 11'($urandom_range(25, 40));
        end
        s.n_skip   = 3'($urandom_range(0, 2));
        s.skip_len = 8'($urandom_range(0, 6));
        s.has_name = ($urandom_range(0, 99) < 85);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          s.name_len = 8'($urandom_range(31, 255));
        end else if (pick < 20) begin
          s.name_len = 8'd0;
        end else begin
          s.name_len = 8'($urandom_range(1, 30));
        end
        name_off = nit_pkg::WALK_START + int'(s.n_skip) * (int'(s.skip_len) + 2);
        if ($urandom_range(0, 99) < 70) begin
          s.loop_len = 12'($urandom_range(name_off - nit_pkg::WALK_START + 1, 4095));
        end else begin
          s.loop_len = 12'($urandom_range(0, 63));
        end
        s.hi_nib = 4'($urandom_range(0, 15));
      end
      send_section(s);
      phase_bytes += int'(s.sec_len);
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_gap_pct   = 10;
    recv_stall_pct = 67;
    foreach (DIRECTED[i]) begin
      send_section(DIRECTED[i]);
    end
    wait_drained();

    run_random_phase(10, 67);
    run_random_phase(67, 10);
    run_random_phase(0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && name_q.size() == 0) begin
      $display("nit_network_name_extractor test passed");
    end else begin
      $display("nit_network_name_extractor test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/nit_pkg.sv
src/nit_front.sv
src/nit_cmd_fifo.sv
src/nit_back.sv
src/nit_network_name_extractor.sv
test/tb_top.sv
